// File: hdl/lsm_pkg.sv
package lsm_pkg;

  // pattern storage in the two 64-bit registers
  localparam int PAT_REG_BYTES = 16;
  localparam int LEN_W         = 5;
  localparam int CFG_AW        = 5;
  localparam int CFG_DW        = 64;
  localparam int CNT_W32       = 32;
  localparam int OUT_DW        = 72;

  // register indexes (paddr[4:3])
  localparam logic [1:0] REG_PAT_FIRST = 2'd0;
  localparam logic [1:0] REG_PAT_LAST  = 2'd1;
  localparam logic [1:0] REG_PAT_LEN   = 2'd2;
  localparam logic [1:0] REG_FOLD      = 2'd3;

  // input tuser codes
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOF  = 1'b1;

  // output tuser codes
  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  localparam logic [CNT_W32-1:0] SAT32 = '1;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic       shift;
    logic       clear;
    logic       fold;
    logic [7:0] text;   // already folded
  } cell_ctl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c inside {[CH_UPPER_A:CH_UPPER_Z]})) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// File: hdl/lsm_cell.sv
module lsm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  lsm_pkg::cell_ctl_t ctl,
  input  logic [7:0]        pat_byte,
  input  logic              enable,    // position is inside the pattern length
  input  logic              last,      // position is the final pattern byte
  input  logic              prev_bit,
  output logic              match_bit,
  output logic              hit
);
  import lsm_pkg::*;

  logic match_r;
  logic match_nxt;
  logic eq;

  assign eq = (fold_byte(pat_byte, ctl.fold) == ctl.text);

  always_comb begin
    match_nxt = match_r;
    if (ctl.clear) begin
      match_nxt = 1'b0;
    end else if (ctl.shift) begin
      match_nxt = prev_bit & enable & eq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign match_bit = match_r;
  assign hit       = ctl.shift & last & match_nxt;

endmodule

// File: hdl/line_substring_matcher.sv
// Fixed-string line matcher. Text enters one byte per transfer on in_*
// (in_tuser 0 = text byte, 1 = end of file) and the block sustains one
// byte per clock: every cycle each cell of a shift-and chain compares the
// byte with its pattern byte and takes the partial-match bit of its left
// neighbor, so the whole pattern is checked in a single step. A line ends
// at a newline or at the byte arriving once LINE_LIMIT bytes are held;
// that byte yields a line report in the output register in the next cycle.
// in_tready only drops while a report sits in the output register and
// out_tready is low. End of file reports the match count and clears the
// line state; pattern registers are kept. Counters saturate at 2^32-1.
module line_substring_matcher #(
  parameter int PATTERN_MAX = 16,
  parameter int LINE_LIMIT  = 1023
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // data_byte
  input  logic                         in_tuser,   // command
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [lsm_pkg::OUT_DW-1:0]   out_tdata,  // matched, line_num[32], hit_cnt[32], pad
  output logic                         out_tuser,  // result_kind
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [lsm_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [lsm_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [lsm_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import lsm_pkg::*;

  localparam int NCELL = (PATTERN_MAX < PAT_REG_BYTES) ? PATTERN_MAX : PAT_REG_BYTES;
  localparam int CNT_W = $clog2(LINE_LIMIT + 1);
  localparam logic [LEN_W-1:0] NCELL_LEN = LEN_W'(NCELL);
  localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(LINE_LIMIT);

  // configuration
  logic [63:0]      pat_first_r;
  logic [63:0]      pat_last_r;
  logic [LEN_W-1:0] pat_len_r;
  logic             fold_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_first_r <= '0;
      pat_last_r  <= '0;
      pat_len_r   <= '0;
      fold_r      <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:3])
        REG_PAT_FIRST: pat_first_r <= cfg_pwdata;
        REG_PAT_LAST:  pat_last_r  <= cfg_pwdata;
        REG_PAT_LEN:   pat_len_r   <= cfg_pwdata[LEN_W-1:0];
        REG_FOLD:      fold_r      <= cfg_pwdata[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:3])
      REG_PAT_FIRST: cfg_prdata = pat_first_r;
      REG_PAT_LAST:  cfg_prdata = pat_last_r;
      REG_PAT_LEN:   cfg_prdata = {{(CFG_DW-LEN_W){1'b0}}, pat_len_r};
      REG_FOLD:      cfg_prdata = {{(CFG_DW-1){1'b0}}, fold_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // line state
  logic               found_r,    found_nxt;
  logic [CNT_W-1:0]   bytes_r,    bytes_nxt;
  logic [31:0]        line_num_r, line_num_nxt;
  logic [31:0]        match_r,    match_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r;
  logic               out_hit_r;
  logic [31:0]        out_num_r;
  logic [31:0]        out_cnt_r;

  logic               in_acc;
  logic               is_eof;
  logic               line_end;
  logic               line_hit;
  logic [31:0]        match_inc;
  logic               emit;
  logic [LEN_W-1:0]   len_used;
  logic [8*PAT_REG_BYTES-1:0] pat_all;
  cell_ctl_t          ctl;
  logic [NCELL-1:0]   cell_bit;
  logic [NCELL-1:0]   cell_hit;

  assign in_tready = ~out_valid_r | out_tready;
  assign in_acc    = in_tvalid & in_tready;
  assign is_eof    = (in_tuser == CMD_EOF);
  assign line_end  = ~is_eof & ((in_tdata == CH_NEWLINE) | (bytes_r >= LIMIT_CNT));
  assign len_used  = (pat_len_r > NCELL_LEN) ? NCELL_LEN : pat_len_r;
  assign line_hit  = found_r | (len_used == '0);
  assign match_inc = (line_hit && match_r != SAT32) ? match_r + 32'd1 : match_r;
  assign emit      = in_acc & (is_eof | line_end);
  assign pat_all   = {pat_last_r, pat_first_r};

  assign ctl.shift = in_acc & ~is_eof & ~line_end;
  assign ctl.clear = emit;
  assign ctl.fold  = fold_r;
  assign ctl.text  = fold_byte(in_tdata, fold_r);

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic en;
    logic last;
    assign en   = (LEN_W'(i) < len_used);
    assign last = (LEN_W'(i + 1) == len_used);
    lsm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .pat_byte  (pat_all[8*i +: 8]),
      .enable    (en),
      .last      (last),
      .prev_bit  ((i == 0) ? 1'b1 : cell_bit[(i == 0) ? 0 : i-1]),
      .match_bit (cell_bit[i]),
      .hit       (cell_hit[i])
    );
  end

  always_comb begin
    found_nxt    = found_r;
    bytes_nxt    = bytes_r;
    line_num_nxt = line_num_r;
    match_nxt    = match_r;
    if (in_acc) begin
      if (is_eof) begin
        found_nxt    = 1'b0;
        bytes_nxt    = '0;
        line_num_nxt = 32'd1;
        match_nxt    = '0;
      end else if (line_end) begin
        found_nxt    = 1'b0;
        bytes_nxt    = '0;
        match_nxt    = match_inc;
        line_num_nxt = (line_num_r != SAT32) ? line_num_r + 32'd1 : line_num_r;
      end else begin
        found_nxt = found_r | (|cell_hit);
        bytes_nxt = bytes_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      bytes_r     <= '0;
      line_num_r  <= 32'd1;
      match_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      found_r     <= found_nxt;
      bytes_r     <= bytes_nxt;
      line_num_r  <= line_num_nxt;
      match_r     <= match_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= is_eof ? KIND_EOF : KIND_LINE;
      out_hit_r  <= is_eof ? 1'b0 : line_hit;
      out_num_r  <= is_eof ? 32'd0 : line_num_r;
      out_cnt_r  <= is_eof ? match_r : match_inc;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {{(OUT_DW-65){1'b0}}, out_cnt_r, out_num_r, out_hit_r};

  // checks
  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_eof) |=> (line_num_r == 32'd1 && match_r == '0 && bytes_r == '0))
    else $error("line state not cleared after end of file");

  a_eof_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_EOF) |-> (out_tdata[32:0] == '0))
    else $error("end of file report carries line fields");

  a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_r <= LIMIT_CNT)
    else $error("byte count past line limit");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (match_r < line_num_r) || (line_num_r == SAT32))
    else $error("match count exceeds finished lines");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while report is stalled");

endmodule

// File: dv/tb_line_substring_matcher.sv
module tb_line_substring_matcher;
  import lsm_pkg::*;

  localparam int PAT_SLOTS      = 16;
  localparam int LINE_MAX       = 1023;
  localparam int DRAIN_CYCLES   = 6;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic       cmd;
    logic [7:0] data;
  } text_item_t;

  typedef struct {
    logic        kind;
    logic        matched;
    logic [31:0] number;
    logic [31:0] count;
  } line_report_t;

  typedef enum {PAT_LETTERS, PAT_RANDOM, PAT_ONES, PAT_ZEROS} pat_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata = '0;
  logic               in_tuser = CMD_DATA;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_DW-1:0]  out_tdata;
  logic               out_tuser;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]  cfg_paddr = '0;
  logic [CFG_DW-1:0]  cfg_pwdata = '0;
  logic [CFG_DW-1:0]  cfg_prdata;
  logic               cfg_pready;

  line_substring_matcher #(
    .PATTERN_MAX(PAT_SLOTS),
    .LINE_LIMIT (LINE_MAX)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // shadow registers
  logic [63:0] cfg_first = '0;
  logic [63:0] cfg_last  = '0;
  logic [4:0]  cfg_len   = '0;
  logic        cfg_fold  = 1'b0;

  // predicted line state
  logic [PAT_SLOTS-1:0] vec_bits = '0;
  logic                 seen_in_line = 1'b0;
  int unsigned          held_bytes = 0;
  logic [31:0]          line_no = 32'd1;
  logic [31:0]          hit_total = '0;

  text_item_t   text_q[$];
  line_report_t line_reports_q[$];
  int unsigned  queued = 0;
  int unsigned  errors = 0;
  int unsigned  send_gap_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  hold_left = 0;
  int unsigned  idle_cycles = 0;

  function automatic int unsigned used_len();
    return (cfg_len > PAT_SLOTS) ? PAT_SLOTS : cfg_len;
  endfunction

  function automatic logic [7:0] pattern_at(input int unsigned i);
    logic [127:0] p;
    p = {cfg_last, cfg_first};
    return p[8*i +: 8];
  endfunction

  function automatic logic [7:0] fold_letter(input logic [7:0] c);
    if (cfg_fold && c >= CH_UPPER_A && c <= CH_UPPER_Z) return c + CASE_OFFSET;
    return c;
  endfunction

  // random case flip, only where folding makes it harmless
  function automatic logic [7:0] case_mix(input logic [7:0] c);
    if (cfg_fold && $urandom_range(1) &&
        ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))) return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] text_byte();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll < 4 && used_len() != 0) return case_mix(pattern_at($urandom_range(used_len() - 1)));
    if (roll < 8) return case_mix(8'h61 + 8'($urandom_range(2)));
    return 8'($urandom_range(255));
  endfunction

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // shift-and scan of one accepted transfer
  task automatic scan_byte(input logic cmd, input logic [7:0] b);
    line_report_t r;
    logic [PAT_SLOTS-1:0] eq, keep;
    logic [7:0] t;
    int unsigned n, i;
    n = used_len();
    if (cmd == CMD_EOF) begin
      r.kind = KIND_EOF;
      r.matched = 1'b0;
      r.number = '0;
      r.count = hit_total;
      line_reports_q.push_back(r);
      vec_bits = '0;
      seen_in_line = 1'b0;
      held_bytes = 0;
      line_no = 32'd1;
      hit_total = '0;
    end else if (b == CH_NEWLINE || held_bytes >= LINE_MAX) begin
      r.kind = KIND_LINE;
      r.matched = seen_in_line || (n == 0);
      if (r.matched && hit_total != '1) hit_total++;
      r.number = line_no;
      r.count = hit_total;
      line_reports_q.push_back(r);
      if (line_no != '1) line_no++;
      vec_bits = '0;
      seen_in_line = 1'b0;
      held_bytes = 0;
    end else begin
      t = fold_letter(b);
      eq = '0;
      for (i = 0; i < n; i++) begin
        if (fold_letter(pattern_at(i)) == t) eq[i] = 1'b1;
      end
      keep = PAT_SLOTS'((32'd1 << n) - 32'd1);
      vec_bits = ((vec_bits << 1) | PAT_SLOTS'(1)) & eq & keep;
      if (n != 0) begin
        if (vec_bits[n-1]) seen_in_line = 1'b1;
      end
      held_bytes++;
    end
  endtask

  // sender
  always @(posedge clk) begin : drive
    text_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) scan_byte(in_tuser, in_tdata);
      if (!in_tvalid || in_tready) begin
        if (text_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = text_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nxt.data;
          in_tuser <= nxt.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : receive
    line_report_t want, got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser;
        got.matched = out_tdata[0];
        got.number = out_tdata[32:1];
        got.count = out_tdata[64:33];
        if (line_reports_q.size() == 0) begin
          note_failure($sformatf("unexpected report: kind %0d matched %0d line %0d count %0d",
                                 got.kind, got.matched, got.number, got.count));
        end else begin
          want = line_reports_q.pop_front();
          if (got.kind !== want.kind || got.matched !== want.matched ||
              got.number !== want.number || got.count !== want.count) begin
            note_failure($sformatf(
              "mismatch: kind %0d/%0d matched %0d/%0d line %0d/%0d count %0d/%0d (exp/act)",
              want.kind, got.kind, want.matched, got.matched,
              want.number, got.number, want.count, got.count));
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_item(input logic cmd, input logic [7:0] b);
    text_item_t it;
    it.cmd = cmd;
    it.data = b;
    text_q.push_back(it);
    queued++;
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_item(CMD_DATA, s[i]);
  endtask

  task automatic push_eof();
    push_item(CMD_EOF, 8'($urandom_range(255)));
  endtask

  // all accepted, all reports back, then let a trailing byte settle
  task automatic wait_drained();
    while (text_q.size() != 0 || in_tvalid || line_reports_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_PAT_FIRST: cfg_first = val;
      REG_PAT_LAST:  cfg_last = val;
      REG_PAT_LEN:   cfg_len = val[4:0];
      REG_FOLD:      cfg_fold = val[0];
      default: ;
    endcase
  endtask

  task automatic load_pattern(input pat_style_t style, input logic [4:0] len,
                              input logic fold);
    logic [127:0] p;
    logic [7:0] c;
    int i;
    for (i = 0; i < PAT_SLOTS; i++) begin
      case (style)
        PAT_LETTERS: begin
          c = 8'h61 + 8'($urandom_range(2));
          if ($urandom_range(1)) c = c - CASE_OFFSET;
        end
        PAT_RANDOM: c = 8'($urandom_range(255));
        PAT_ONES:   c = 8'hFF;
        default:    c = 8'h00;
      endcase
      p[8*i +: 8] = c;
    end
    write_reg(REG_PAT_FIRST, p[63:0]);
    write_reg(REG_PAT_LAST, p[127:64]);
    write_reg(REG_PAT_LEN, 64'(len));
    write_reg(REG_FOLD, 64'(fold));
  endtask

  // short lines over a small alphabet, often carrying the whole pattern
  task automatic queue_text(input int unsigned n_items);
    int unsigned stop, len, pos, j, k, roll;
    stop = queued + n_items;
    while (queued < stop) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        push_eof();
      end else begin
        len = $urandom_range(20);
        pos = $urandom_range(len);
        for (j = 0; j <= len; j++) begin
          if (roll < 60 && j == pos) begin
            for (k = 0; k < used_len(); k++) push_item(CMD_DATA, case_mix(pattern_at(k)));
          end
          if (j < len) push_item(CMD_DATA, text_byte());
        end
        // a few lines stay open and run into the next one
        if (roll >= 8) push_item(CMD_DATA, CH_NEWLINE);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned gaps[4]   = '{0, 53, 0, 6};
    int unsigned stalls[4] = '{0, 0, 53, 6};
    logic [4:0]  lens[8]   = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd5, 5'd17, 5'd8, 5'd2};
    logic        folds[8]  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    pat_style_t  styles[8] = '{PAT_LETTERS, PAT_LETTERS, PAT_RANDOM, PAT_ONES,
                               PAT_LETTERS, PAT_ZEROS, PAT_RANDOM, PAT_LETTERS};
    int ph, j;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty pattern after reset: every line matches, the empty one too
    push_text("\n");
    push_item(CMD_DATA, 8'h00);
    push_item(CMD_DATA, 8'hFF);
    push_text("\n");
    push_eof();
    wait_drained();

    write_reg(REG_PAT_FIRST, 64'h6241);
    write_reg(REG_PAT_LAST, 64'h0);
    write_reg(REG_PAT_LEN, 64'd2);
    write_reg(REG_FOLD, 64'd1);
    push_text("aB\nzA\n");
    push_eof();
    // open line when the fold setting changes; upper bits of the write are ignored
    push_text("xA");
    wait_drained();
    write_reg(REG_FOLD, 64'hFFFF_FFFF_FFFF_FFFE);
    push_text("b\nab\nAb");
    wait_drained();
    // length over the limit clamps; the match already found in this line stays
    write_reg(REG_PAT_LEN, 64'd17);
    push_text("\n");
    push_eof();
    wait_drained();

    for (ph = 0; ph < 8; ph++) begin
      @(negedge clk);
      send_gap_pct = gaps[ph % 4];
      stall_pct = stalls[ph % 4];
      load_pattern(styles[ph], lens[ph], folds[ph]);
      @(negedge clk);
      queue_text(90);
      wait_drained();
    end

    // receiver holds off while the sender keeps pushing
    load_pattern(PAT_LETTERS, 5'd3, 1'b1);
    @(negedge clk);
    send_gap_pct = 0;
    stall_pct = 0;
    hold_left = HOLD_CYCLES;
    queue_text(120);
    wait_drained();

    // one line running into the length limit
    load_pattern(PAT_LETTERS, 5'd3, 1'b0);
    @(negedge clk);
    send_gap_pct = gaps[3];
    stall_pct = stalls[3];
    for (j = 0; j < LINE_MAX; j++) begin
      if (j >= 500 && j < 503) push_item(CMD_DATA, pattern_at(j - 500));
      else push_item(CMD_DATA, 8'h64 + 8'($urandom_range(1)));
    end
    push_item(CMD_DATA, 8'h71);   // arrives with the line full: ends it, then dropped
    push_text("\n");
    push_eof();
    wait_drained();

    if (line_reports_q.size() != 0) begin
      note_failure($sformatf("%0d reports never arrived", line_reports_q.size()));
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
